[rtl/core/sld_pkg.sv]
// Package for the sync-word / length-field deframer.
// Holds the result and configuration types, field widths, result kind codes,
// register indexes and reset values. Depends on nothing.
package sld_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SYNC_W    = 32;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned OVH_W     = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned POS_W     = 17;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD_BYTES = 2'd2;

    // Configuration reset values.
    localparam logic [SYNC_W-1:0] SYNC_WORD_RST      = 32'h1234_5679;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST     = 16'd1000;
    localparam logic [OVH_W-1:0]  OVERHEAD_BYTES_RST = 8'd22;

    // Fixed frame positions: four sync bytes, then two length bytes.
    localparam logic [POS_W-1:0] POS_LEN_LOW  = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_HIGH = 17'd5;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 17'd6;

    typedef struct packed {
        logic [SYNC_W-1:0] sync_word;
        logic [LEN_W-1:0]  max_length;
        logic [OVH_W-1:0]  overhead_bytes;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [LEN_W-1:0]  byte_index;
        logic              last;
    } t_result;

endpackage

[rtl/core/sync_length_deframer_top.sv]
// Top level of the streaming sync-word / length-field deframer.
// Instantiates sld_cfg_regs, sld_pipe_reg (input and result) and sld_parse.
// Depends on sld_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   rx        in         i_rx_valid / o_rx_ready   i_rx_byte
//   result    out        o_res_valid / i_res_ready o_kind, o_data_byte,
//                                                  o_frame_length, o_byte_index, o_last
//   cfg       in         i_cfg_wr_en (no wait)     i_cfg_index, i_cfg_wdata
//
// One byte is taken per cycle while the result side does not hold the parser.
// A result passes through the input register and then the result register.
// Reset is synchronous and active low; it returns the parser to the sync hunt,
// empties both registers and restores the default configuration.
// A stalled result holds the parser once its current byte gives a result of its
// own; bytes that give none still pass. The input register holds the waiting byte,
// and o_rx_ready stays low while that byte waits.
module sync_length_deframer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [sld_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [sld_pkg::KIND_W-1:0]    o_kind,
    output logic [sld_pkg::BYTE_W-1:0]    o_data_byte,
    output logic [sld_pkg::LEN_W-1:0]     o_frame_length,
    output logic [sld_pkg::LEN_W-1:0]     o_byte_index,
    output logic                          o_last,
    input  logic                          i_cfg_wr_en,
    input  logic [sld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sld_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);
    import sld_pkg::*;

    localparam int unsigned RES_W = $bits(t_result);

    t_cfg              cfg;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_q;
    logic              step_fire;
    logic              step_res_valid;
    t_result           step_res;
    logic              res_ready;
    t_result           res_q;

    sld_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Input register: holds the byte being worked on.
    sld_pipe_reg #(
        .WIDTH (BYTE_W)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .o_ready (o_rx_ready),
        .i_data  (i_rx_byte),
        .o_valid (byte_valid),
        .i_ready (step_fire),
        .o_data  (byte_q)
    );

    // A byte is consumed when it gives no result, or when the result register
    // has room for the one it gives.
    assign step_fire = byte_valid && (!step_res_valid || res_ready);

    sld_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (step_fire),
        .i_byte      (byte_q),
        .i_cfg       (cfg),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    // Result register: a finished result waits here for its transaction.
    sld_pipe_reg #(
        .WIDTH (RES_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (byte_valid && step_res_valid),
        .o_ready (res_ready),
        .i_data  (step_res),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (res_q)
    );

    assign o_kind         = res_q.kind;
    assign o_data_byte    = res_q.data_byte;
    assign o_frame_length = res_q.frame_length;
    assign o_byte_index   = res_q.byte_index;
    assign o_last         = res_q.last;

endmodule

[rtl/core/sld_cfg_regs.sv]
// Configuration register file of the deframer: sync word, length limit and
// frame overhead. Depends on sld_pkg.
module sld_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sld_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    output sld_pkg::t_cfg                 o_cfg
);
    import sld_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word      <= SYNC_WORD_RST;
            r_cfg.max_length     <= MAX_LENGTH_RST;
            r_cfg.overhead_bytes <= OVERHEAD_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SYNC_WORD:      r_cfg.sync_word      <= i_cfg_wdata[SYNC_W-1:0];
                CFG_MAX_LENGTH:     r_cfg.max_length     <= i_cfg_wdata[LEN_W-1:0];
                CFG_OVERHEAD_BYTES: r_cfg.overhead_bytes <= i_cfg_wdata[OVH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/sld_pipe_reg.sv]
// One-entry valid/ready pipeline register, used for the input byte and for
// the result. Depends on sld_pkg for the default width.
module sld_pipe_reg #(
    parameter int unsigned WIDTH = sld_pkg::BYTE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    import sld_pkg::*;

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // The entry can be refilled in the same cycle in which it drains.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/core/sld_parse.sv]
// Frame parser of the deframer: sync hunt, length capture and data counting.
// Computes the result of one byte and updates the frame state when told to.
// Depends on sld_pkg.
module sld_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [sld_pkg::BYTE_W-1:0] i_byte,
    input  sld_pkg::t_cfg              i_cfg,
    output logic                       o_res_valid,
    output sld_pkg::t_result           o_res
);
    import sld_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_position, n_position;
    logic [BYTE_W-1:0]  r_length_low, n_length_low;
    logic [POS_W-1:0]   r_frame_total, n_frame_total;

    logic [1:0]         hunt_pos;
    logic [BYTE_W-1:0]  want;
    logic [LEN_W-1:0]   len;
    logic [POS_W-1:0]   total;
    logic               fin;

    always_comb begin
        // Hunting restarts from the first sync byte if the count is out of range
        // or the phase code is the unused one.
        hunt_pos = (r_phase != PH_HUNT || r_position > 17'd3) ? 2'd0 : r_position[1:0];
        case (hunt_pos)
            2'd0:    want = i_cfg.sync_word[31:24];
            2'd1:    want = i_cfg.sync_word[23:16];
            2'd2:    want = i_cfg.sync_word[15:8];
            default: want = i_cfg.sync_word[7:0];
        endcase
        len   = {i_byte, r_length_low};
        total = {1'b0, len} + {{(POS_W-OVH_W){1'b0}}, i_cfg.overhead_bytes};
        fin   = ({1'b0, r_position} + 18'd1) >= {1'b0, r_frame_total};
    end

    always_comb begin
        n_phase       = r_phase;
        n_position    = r_position;
        n_length_low  = r_length_low;
        n_frame_total = r_frame_total;
        o_res_valid   = 1'b0;
        o_res         = '0;
        unique case (r_phase)
            PH_LEN: begin
                if (r_position == POS_LEN_LOW) begin
                    n_length_low = i_byte;
                    n_position   = POS_LEN_HIGH;
                end else begin
                    o_res_valid        = 1'b1;
                    o_res.frame_length = len;
                    o_res.byte_index   = POS_LEN_HIGH[LEN_W-1:0];
                    if (len > i_cfg.max_length) begin
                        o_res.kind = KIND_REJECT;
                        n_phase    = PH_HUNT;
                        n_position = '0;
                    end else begin
                        o_res.kind    = KIND_START;
                        n_frame_total = total;
                        n_phase       = PH_DATA;
                        n_position    = POS_FIRST_DATA;
                    end
                end
            end
            PH_DATA: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_BYTE;
                o_res.data_byte  = i_byte;
                o_res.byte_index = r_position[LEN_W-1:0];
                o_res.last       = fin;
                if (fin) begin
                    n_phase    = PH_HUNT;
                    n_position = '0;
                end else begin
                    n_position = r_position + 17'd1;
                end
            end
            default: begin
                // Hunting; the unused phase code behaves the same way.
                n_phase = PH_HUNT;
                if (i_byte == want) begin
                    n_position = {{(POS_W-3){1'b0}}, {1'b0, hunt_pos} + 3'd1};
                    if (hunt_pos == 2'd3) begin
                        n_phase = PH_LEN;
                    end
                end else begin
                    n_position = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_position    <= '0;
            r_length_low  <= '0;
            r_frame_total <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_length_low  <= n_length_low;
            r_frame_total <= n_frame_total;
        end
    end

endmodule
